/* rtl/dqs_pkg.sv */
// Package for the double-ended queue with sort: sizes, command and status codes,
// engine states and the request/response structs.
// No dependencies; used by dqs_engine and double_ended_queue_with_sort.
package dqs_pkg;

   // Store geometry
   localparam int DEPTH   = 16;
   localparam int WORD_W  = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // Field widths fixed by the interface
   localparam int OP_W     = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Command codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 4'd0,
      OP_PUSH_BACK  = 4'd1,
      OP_POP_FRONT  = 4'd2,
      OP_POP_BACK   = 4'd3,
      OP_PEEK_FRONT = 4'd4,
      OP_PEEK_BACK  = 4'd5,
      OP_CLEAR      = 4'd6,
      OP_REVERSE    = 4'd7,
      OP_SORT       = 4'd8
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Engine sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SRD0,
      S_SCUR,
      S_SCMP,
      S_SEND
   } eng_state_type;

   // One command; op in the low bits
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [OP_W-1:0]   op;
   } cmd_type;

   // One result; data in the low bits
   typedef struct packed {
      status_type          status;
      logic                is_empty;
      logic [COUNT_W-1:0]  count;
      logic [WORD_W-1:0]   data_out;
   } rsp_type;

endpackage

/* rtl/dqs_engine.sv */
// Deque engine: circular word store in a synchronous memory, end pointers,
// command sequencer and the in-place sort over the memory.
// Depends on dqs_pkg.
module dqs_engine import dqs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,      // command accepted this cycle
   input  cmd_type cmd,
   output logic    ready,      // sequencer idle
   output logic    res_valid,  // one result this cycle
   output rsp_type res
);

   // Word store, one write and one registered read per cycle
   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;

   eng_state_type state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rev_ff, rev_in;

   // Sort working registers: carried word, position in pass, pass length
   logic [WORD_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  len_ff, len_in;

   // (a + b) mod DEPTH for a, b below DEPTH
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(DEPTH)) begin
         s = s - (IDX_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   // Physical slot of a logical position (0 is the logical front)
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt,
                                                input logic             rev,
                                                input logic [IDX_W-1:0] pos);
      logic [CNT_W-1:0] back;
      logic [IDX_W-1:0] off;
      back = cnt - CNT_W'(1) - CNT_W'(pos);
      off  = rev ? back[IDX_W-1:0] : pos;
      return wrap_add(head, off);
   endfunction

   // Memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store_mem[mem_raddr];
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Sequencer
   always_comb begin
      logic [IDX_W-1:0] last_pos;
      logic [IDX_W-1:0] head_dec;
      logic             low_end;
      status_type       st;

      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      mem_we    = 1'b0;
      mem_waddr = head_ff;
      mem_wdata = cmd.value;
      mem_raddr = head_ff;
      res_valid = 1'b0;
      st        = ST_OK;

      last_pos = IDX_W'(count_ff - CNT_W'(1));
      head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
      low_end  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (cmd.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     res_valid = 1'b1;
                     low_end   = (cmd.op == OP_PUSH_FRONT) == !rev_ff;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        st = ST_FULL;
                     end else if (low_end) begin
                        mem_we    = 1'b1;
                        mem_waddr = head_dec;
                        head_in   = head_dec;
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = wrap_add(head_ff, IDX_W'(count_ff));
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     low_end = (cmd.op == OP_POP_FRONT) == !rev_ff;
                     if (count_ff == '0) begin
                        res_valid = 1'b1;
                        st        = ST_EMPTY;
                     end else if (low_end) begin
                        mem_raddr = head_ff;
                        head_in   = wrap_add(head_ff, IDX_W'(1));
                        count_in  = count_ff - CNT_W'(1);
                        state_in  = S_READ;
                     end else begin
                        mem_raddr = wrap_add(head_ff, last_pos);
                        count_in  = count_ff - CNT_W'(1);
                        state_in  = S_READ;
                     end
                  end
                  OP_PEEK_FRONT, OP_PEEK_BACK: begin
                     if (count_ff == '0) begin
                        res_valid = 1'b1;
                        st        = ST_EMPTY;
                     end else begin
                        mem_raddr = slot_of(head_ff, count_ff, rev_ff,
                                            (cmd.op == OP_PEEK_FRONT) ? '0 : last_pos);
                        state_in  = S_READ;
                     end
                  end
                  OP_CLEAR: begin
                     res_valid = 1'b1;
                     head_in   = '0;
                     count_in  = '0;
                     rev_in    = 1'b0;
                  end
                  OP_REVERSE: begin
                     res_valid = 1'b1;
                     rev_in    = !rev_ff;
                  end
                  OP_SORT: begin
                     if (count_ff < CNT_W'(2)) begin
                        res_valid = 1'b1;
                     end else begin
                        len_in   = count_ff;
                        state_in = S_SRD0;
                     end
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end
         // Pop or peek word arrives from the memory
         S_READ: begin
            res_valid = 1'b1;
            state_in  = S_IDLE;
         end
         // Start of a pass: fetch logical position 0
         S_SRD0: begin
            mem_raddr = slot_of(head_ff, count_ff, rev_ff, '0);
            state_in  = S_SCUR;
         end
         // First word becomes the carried word; fetch position 1
         S_SCUR: begin
            cur_in    = rdata_ff;
            mem_raddr = slot_of(head_ff, count_ff, rev_ff, IDX_W'(1));
            pos_in    = IDX_W'(1);
            state_in  = S_SCMP;
         end
         // Keep the larger word, drop the smaller one a place behind
         S_SCMP: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(head_ff, count_ff, rev_ff, pos_ff - IDX_W'(1));
            if ($signed(cur_ff) > $signed(rdata_ff)) begin
               mem_wdata = rdata_ff;
            end else begin
               mem_wdata = cur_ff;
               cur_in    = rdata_ff;
            end
            if (pos_ff == IDX_W'(len_ff - CNT_W'(1))) begin
               state_in = S_SEND;
            end else begin
               mem_raddr = slot_of(head_ff, count_ff, rev_ff, pos_ff + IDX_W'(1));
               pos_in    = pos_ff + IDX_W'(1);
            end
         end
         // Largest word of the pass lands at the end of the pass
         S_SEND: begin
            mem_we    = 1'b1;
            mem_wdata = cur_ff;
            mem_waddr = slot_of(head_ff, count_ff, rev_ff, IDX_W'(len_ff - CNT_W'(1)));
            if (len_ff == CNT_W'(2)) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end else begin
               len_in   = len_ff - CNT_W'(1);
               state_in = S_SRD0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.data_out = (state_ff == S_READ) ? rdata_ff : '0;
      res.count    = COUNT_W'(count_in);
      res.is_empty = (count_in == '0);
      res.status   = st;
      ready        = (state_ff == S_IDLE);
   end

endmodule

/* rtl/double_ended_queue_with_sort.sv */
// Top level of the double-ended queue with sort: stream ports, command decode
// into the engine and a two-entry response queue.
// Depends on dqs_pkg and dqs_engine.

// A bounded deque of 16 signed 32-bit words. Each request is one command
// (push, pop or peek at either end, clear, reverse, sort ascending) and gives
// exactly one response with the popped or peeked word, the count after the
// command, an empty flag and a status. Push, clear, reverse, unused codes and
// rejected pushes, pops or peeks respond from the idle state; a pop or peek of
// a stored word responds from the read state, once the registered read of the
// word memory is back. Sort of fewer than two words responds from the idle
// state; sort of n words makes n-1 passes over the single memory read port,
// each pass through the states S_SRD0, S_SCUR, S_SCMP and S_SEND. Requests
// are taken while the engine is idle and up to one response waits at the output.
module double_ended_queue_with_sort import dqs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // op[3:0], value[35:4], zero fill[39:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // data_out[31:0], count[36:32],
                                    // is_empty[37], status[39:38]
);

   logic    eng_ready;
   logic    eng_start;
   logic    eng_res_valid;
   rsp_type eng_res;
   cmd_type req_cmd;

   // Response queue, entry 0 drives the port
   rsp_type    q0_ff, q0_in;
   rsp_type    q1_ff, q1_in;
   logic [1:0] qcnt_ff, qcnt_in;
   logic       q_pop;

   assign req_cmd    = req_tdata[OP_W+WORD_W-1:0];
   assign req_tready = eng_ready && (qcnt_ff != 2'd2);
   assign eng_start  = req_tvalid && req_tready;

   dqs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (eng_start),
      .cmd       (req_cmd),
      .ready     (eng_ready),
      .res_valid (eng_res_valid),
      .res       (eng_res)
   );

   // Queue update
   always_comb begin
      q_pop   = (qcnt_ff != 2'd0) && rsp_tready;
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      qcnt_in = qcnt_ff;
      if (q_pop && eng_res_valid) begin
         if (qcnt_ff == 2'd1) begin
            q0_in = eng_res;
         end else begin
            q0_in = q1_ff;
            q1_in = eng_res;
         end
      end else if (q_pop) begin
         q0_in   = q1_ff;
         qcnt_in = qcnt_ff - 2'd1;
      end else if (eng_res_valid) begin
         if (qcnt_ff == 2'd0) begin
            q0_in = eng_res;
         end else begin
            q1_in = eng_res;
         end
         qcnt_in = qcnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= 2'd0;
      end else begin
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_tvalid = (qcnt_ff != 2'd0);
   assign rsp_tdata  = q0_ff;

endmodule

/* dv/dqs_scoreboard_pkg.sv */
// Scoreboard for the double-ended queue with sort: a deque predictor that
// turns each accepted request into its expected response and checks responses.
// Depends on dqs_pkg for sizes, command codes and the request/response structs.
package dqs_scoreboard_pkg;
   import dqs_pkg::*;

   class deque_scoreboard;
      // Predictor state: circular word store, low-end index, fill level, direction
      logic [WORD_W-1:0] words [DEPTH];
      int                head;
      int                held;
      bit                flipped;

      rsp_type           expected_q [$];
      int                error_count;
      int                checked_count;

      function void clear_state();
         head    = 0;
         held    = 0;
         flipped = 0;
      endfunction

      // Physical slot of logical position pos (0 is the logical front)
      function int slot(int pos);
         int off;
         off = flipped ? held - 1 - pos : pos;
         return (head + off) % DEPTH;
      endfunction

      // Bubble sort over the logical order, signed compare
      function void sort_ascending();
         logic signed [WORD_W-1:0] seq [DEPTH];
         logic signed [WORD_W-1:0] tmp;
         for (int a = 0; a < held; a++) seq[a] = words[slot(a)];
         for (int a = 0; a < held - 1; a++)
            for (int b = 0; b < held - 1 - a; b++)
               if (seq[b] > seq[b+1]) begin
                  tmp      = seq[b];
                  seq[b]   = seq[b+1];
                  seq[b+1] = tmp;
               end
         for (int a = 0; a < held; a++) words[slot(a)] = seq[a];
      endfunction

      // Apply one command to the predictor and build its response
      function rsp_type predict(cmd_type c);
         rsp_type r;
         bit      low_end;
         r        = '0;
         r.status = ST_OK;
         case (c.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               low_end = (c.op == OP_PUSH_FRONT) != flipped;
               if (held >= DEPTH) begin
                  r.status = ST_FULL;
               end else if (low_end) begin
                  head        = (head + DEPTH - 1) % DEPTH;
                  words[head] = c.value;
                  held++;
               end else begin
                  words[(head + held) % DEPTH] = c.value;
                  held++;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               low_end = (c.op == OP_POP_FRONT) != flipped;
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else if (low_end) begin
                  r.data_out = words[head];
                  head       = (head + 1) % DEPTH;
                  held--;
               end else begin
                  r.data_out = words[(head + held - 1) % DEPTH];
                  held--;
               end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.data_out = words[slot(c.op == OP_PEEK_FRONT ? 0 : held - 1)];
               end
            end
            OP_CLEAR: begin
               clear_state();
            end
            OP_REVERSE: begin
               flipped = !flipped;
            end
            OP_SORT: begin
               sort_ascending();
            end
            default: ;  // unused codes do nothing
         endcase
         r.count    = COUNT_W'(held);
         r.is_empty = (held == 0);
         return r;
      endfunction

      function void note_command(cmd_type c);
         expected_q = {expected_q, predict(c)};
      endfunction

      // Compare one response against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         checked_count++;
         if (expected_q.size() == 0) begin
            $error("response with no request pending: data_out %0d count %0d",
                   $signed(got.data_out), got.count);
            error_count++;
            return;
         end
         want = expected_q[0];
         expected_q.delete(0);
         if (got.data_out !== want.data_out) begin
            $error("data_out: expected %0d, actual %0d",
                   $signed(want.data_out), $signed(got.data_out));
            error_count++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            error_count++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
            error_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

/* dv/tb_double_ended_queue_with_sort.sv */
// Testbench top for double_ended_queue_with_sort: directed and random command
// streams with random idling on both sides, one long response hold-off.
// Depends on dqs_pkg, dqs_scoreboard_pkg and the RTL top level.
module tb_double_ended_queue_with_sort;
   timeunit 1ns;
   timeprecision 1ps;

   import dqs_pkg::*;
   import dqs_scoreboard_pkg::*;

   // Command codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 160;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // op[3:0], value[35:4], zero fill[39:36]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // data_out[31:0], count[36:32], is_empty[37], status[39:38]

   deque_scoreboard sb = new();
   bit              req_burst;

   double_ended_queue_with_sort u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin
      #1_000_000;
      $display("status: fail");
      $finish;
   end

   // Idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         4, 5:    return WORD_W'($signed($urandom_range(15)) - 8);
         default: return $urandom();
      endcase
   endfunction

   function automatic cmd_type make_cmd(logic [OP_W-1:0] op, logic [WORD_W-1:0] value);
      cmd_type c;
      c.op    = op;
      c.value = value;
      return c;
   endfunction

   // Random command; fill_bias is the percentage of pushes
   function automatic cmd_type random_command(int fill_bias);
      int               pick;
      logic [OP_W-1:0]  op;
      pick = $urandom_range(99);
      if (pick < fill_bias)
         op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (pick < 80)
         case ($urandom_range(5))
            0, 1:    op = OP_POP_FRONT;
            2, 3:    op = OP_POP_BACK;
            4:       op = OP_PEEK_FRONT;
            default: op = OP_PEEK_BACK;
         endcase
      else if (pick < 88)
         op = OP_REVERSE;
      else if (pick < 94)
         op = OP_SORT;
      else if (pick < 96)
         op = OP_CLEAR;
      else
         op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      return make_cmd(op, random_word());
   endfunction

   // Offer one request and wait for its handshake
   task automatic send_command(cmd_type c);
      int gap;
      gap = req_burst ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_command(c);
   endtask

   // Response side: random stalls, free-running stretches, one long hold-off
   initial begin
      int stall_left;
      int run_left;
      bit hold_done;
      bit ready_next;
      stall_left = 0;
      run_left   = 0;
      hold_done  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_type'(rsp_tdata));
         if (!hold_done && sb.checked_count >= 60) begin
            hold_done  = 1;
            stall_left = HOLD_CYCLES;
            run_left   = 0;
         end
         if (stall_left == 0 && run_left == 0) begin
            if ($urandom_range(1)) run_left = $urandom_range(1, 40);
            else stall_left = idle_len() + 1;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            run_left--;
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   // Request side: reset, directed commands, random phases, drain
   initial begin
      cmd_type directed_q [$];
      int      sent;
      int      phase_len;
      int      fill_bias;
      sb.clear_state();
      req_burst  = 0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      reset      <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty deque: rejected pops and peeks, sort and reverse with no words
      directed_q = {directed_q, make_cmd(OP_POP_FRONT, '1)};
      directed_q = {directed_q, make_cmd(OP_POP_BACK, '0)};
      directed_q = {directed_q, make_cmd(OP_PEEK_FRONT, '0)};
      directed_q = {directed_q, make_cmd(OP_PEEK_BACK, '0)};
      directed_q = {directed_q, make_cmd(OP_SORT, '0)};
      directed_q = {directed_q, make_cmd(OP_REVERSE, '0)};
      // Fill to capacity while reversed, extreme and duplicate words
      for (int i = 0; i < DEPTH; i++)
         directed_q = {directed_q, make_cmd(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
            (i % 4 == 0) ? 32'h7fff_ffff : (i % 4 == 1) ? 32'h8000_0000 :
            (i % 4 == 2) ? 32'hffff_ffff : WORD_W'(i))};
      // Full deque: rejected push, sort, reads at both ends, unused codes, clear
      directed_q = {directed_q, make_cmd(OP_PUSH_BACK, 32'h1234_5678)};
      directed_q = {directed_q, make_cmd(OP_SORT, '0)};
      directed_q = {directed_q, make_cmd(OP_PEEK_FRONT, '0)};
      directed_q = {directed_q, make_cmd(OP_PEEK_BACK, '0)};
      directed_q = {directed_q, make_cmd(OP_REVERSE, '0)};
      directed_q = {directed_q, make_cmd(OP_POP_FRONT, '0)};
      directed_q = {directed_q, make_cmd(OP_POP_BACK, '0)};
      directed_q = {directed_q, make_cmd(OP_UNUSED_LO, '1)};
      directed_q = {directed_q, make_cmd(OP_UNUSED_HI, '0)};
      directed_q = {directed_q, make_cmd(OP_CLEAR, '0)};
      foreach (directed_q[i]) send_command(directed_q[i]);

      // Random phases that lean toward filling, draining or neither
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(15, 60);
         case ($urandom_range(2))
            0:       fill_bias = 70;
            1:       fill_bias = 45;
            default: fill_bias = 20;
         endcase
         req_burst = ($urandom_range(3) == 0);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            send_command(random_command(fill_bias));
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // Wait out the remaining responses, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
